>>> hw/rtl/websocket_frame_parser_unit_macros.svh
// Assertion macros for the websocket frame parser unit.
// Needs clk and rst_n in the scope of each use; empty bodies when SYNTH is set.
`ifndef WEBSOCKET_FRAME_PARSER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define WFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfp check failed: same-cycle implication");
// Next-cycle implication
`define WFP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfp check failed: next-cycle implication");
`else
`define WFP_ASSERT_IMP(lbl, ante, cons)
`define WFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/wfp_pkg.sv
// Shared types and constants of the websocket frame parser unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package wfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 27;
    localparam int ACC_W   = 64;
    localparam int KEY_W   = 32;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 48;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 27'h4000000;

    // Length codes in the second header byte
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic ERR_RESERVED  = 1'b0;
    localparam logic ERR_TOO_LARGE = 1'b1;

    // One classified word from the front end to the back end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              fin;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] key;
        logic              last;
        logic              err_code;
    } cmd_t;

    // Push of one command into the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

endpackage

>>> hw/rtl/wfp_front.sv
// Front end: accepts wire bytes, tracks header parsing and classifies each byte.
// Depends on wfp_pkg; pushes classified words into wfp_queue.
`timescale 1ns / 1ps

module wfp_front
    import wfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [LEN_W-1:0] max_len,
    output push_t            push,
    output logic             in_error
);

    localparam logic [2:0] PH_B0   = 3'd0;
    localparam logic [2:0] PH_B1   = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] hdr0_reg, hdr0_next;
    logic              mask_reg, mask_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  off_reg, off_next;

    logic [ACC_W-1:0]  len_sel;
    logic              len_mask;
    logic              too_big;
    logic [ACC_W-1:0]  hdr_len;
    logic [ACC_W-1:0]  off_inc;
    logic [BYTE_W-1:0] key_byte;
    cmd_t              cmd;
    logic              emit;

    // Length that completes on this byte, and its limit check
    always_comb
    begin
        if (phase_reg == PH_EXT)
        begin
            len_sel  = {acc_reg[ACC_W-BYTE_W-1:0], in_byte};
            len_mask = mask_reg;
        end
        else
        begin
            len_sel  = {{(ACC_W-7){1'b0}}, in_byte[6:0]};
            len_mask = in_byte[7];
        end
        too_big = (|len_sel[ACC_W-1:LEN_W]) || (len_sel[LEN_W-1:0] > max_len);
    end

    // Key byte for the current payload offset, first wire byte at offset zero
    always_comb
    begin
        case (off_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign off_inc = {{(ACC_W-LEN_W){1'b0}}, off_reg} + {{(ACC_W-1){1'b0}}, 1'b1};

    // Parse step for one accepted byte
    always_comb
    begin
        phase_next = phase_reg;
        hdr0_next  = hdr0_reg;
        mask_next  = mask_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        off_next   = off_reg;
        cmd        = '0;
        emit       = 1'b0;
        hdr_len    = acc_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_B0:
                begin
                    hdr0_next  = in_byte;
                    phase_next = PH_B1;
                end
                PH_B1, PH_EXT:
                begin
                    if (phase_reg == PH_B1)
                    begin
                        mask_next = in_byte[7];
                    end
                    if ((phase_reg == PH_B1) && (hdr0_reg[6:4] != 3'd0))
                    begin
                        emit         = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        cmd.err_code = ERR_RESERVED;
                        phase_next   = PH_ERR;
                    end
                    else if ((phase_reg == PH_B1) && (in_byte[6:0] == LEN_EXT16))
                    begin
                        acc_next   = '0;
                        cnt_next   = 3'd1;
                        phase_next = PH_EXT;
                    end
                    else if ((phase_reg == PH_B1) && (in_byte[6:0] == LEN_EXT64))
                    begin
                        acc_next   = '0;
                        cnt_next   = 3'd7;
                        phase_next = PH_EXT;
                    end
                    else if ((phase_reg == PH_EXT) && (cnt_reg != 3'd0))
                    begin
                        acc_next = len_sel;
                        cnt_next = cnt_reg - 3'd1;
                    end
                    else
                    begin
                        // Length complete: check, then key or header
                        acc_next = len_sel;
                        if (too_big)
                        begin
                            emit         = 1'b1;
                            cmd.kind     = KIND_ERROR;
                            cmd.err_code = ERR_TOO_LARGE;
                            phase_next   = PH_ERR;
                        end
                        else if (len_mask)
                        begin
                            cnt_next   = 3'd3;
                            key_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            hdr_len    = len_sel;
                            cmd.kind   = KIND_HEADER;
                            off_next   = '0;
                            phase_next = (len_sel == '0) ? PH_B0 : PH_DATA;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[KEY_W-BYTE_W-1:0], in_byte};
                    if (cnt_reg == 3'd0)
                    begin
                        emit       = 1'b1;
                        cmd.kind   = KIND_HEADER;
                        off_next   = '0;
                        phase_next = (acc_reg == '0) ? PH_B0 : PH_DATA;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                PH_DATA:
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_PAYLOAD;
                    cmd.data = in_byte;
                    cmd.key  = mask_reg ? key_byte : '0;
                    if (off_inc >= acc_reg)
                    begin
                        cmd.last   = 1'b1;
                        phase_next = PH_B0;
                        off_next   = '0;
                    end
                    else
                    begin
                        off_next = off_inc[LEN_W-1:0];
                    end
                end
                PH_ERR:
                begin
                    phase_next = PH_ERR;
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
            // Header fields come from the stored first byte
            if (emit && (cmd.kind == KIND_HEADER))
            begin
                cmd.fin    = hdr0_reg[7];
                cmd.opcode = hdr0_reg[3:0];
                cmd.masked = mask_next;
                cmd.length = hdr_len[LEN_W-1:0];
                cmd.last   = (hdr_len == '0);
            end
        end
    end

    // Advance parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_B0;
            hdr0_reg  <= '0;
            mask_reg  <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            key_reg   <= '0;
            off_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr0_reg  <= hdr0_next;
            mask_reg  <= mask_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            key_reg   <= key_next;
            off_reg   <= off_next;
        end
    end

    assign push.valid = emit;
    assign push.cmd   = cmd;
    assign in_error   = (phase_reg == PH_ERR);

endmodule

>>> hw/rtl/wfp_queue.sv
// Short queue of classified words between front end and back end.
// Depends on wfp_pkg for the command type.
`timescale 1ns / 1ps

module wfp_queue
    import wfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output cmd_t  head,
    output logic  empty,
    output logic  full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_FULL);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CNT_ONE;
            2'b01:   cnt_next = cnt_reg - CNT_ONE;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

>>> hw/rtl/wfp_back.sv
// Back end: unmasks payload bytes, formats results and holds the output word.
// Depends on wfp_pkg; pops words from wfp_queue.
`timescale 1ns / 1ps

module wfp_back
    import wfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TDATA_W-1:0] out_data,
    output logic [KIND_W-1:0]  out_kind,
    output logic               out_last
);

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               last_reg, last_next;

    assign pop = !empty && (!valid_reg || out_ready);

    // Format the next result, zeroing fields that do not apply to its kind
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            kind_next  = head.kind;
            data_next  = '0;
            last_next  = 1'b0;
            case (head.kind)
                KIND_HEADER:
                begin
                    data_next[0]    = head.fin;
                    data_next[4:1]  = head.opcode;
                    data_next[5]    = head.masked;
                    data_next[32:6] = head.length;
                    last_next       = head.last;
                end
                KIND_PAYLOAD:
                begin
                    data_next[40:33] = head.data ^ head.key;
                    last_next        = head.last;
                end
                KIND_ERROR:
                begin
                    data_next[41] = head.err_code;
                end
                default:
                begin
                    data_next = '0;
                end
            endcase
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the output word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

>>> hw/rtl/websocket_frame_parser_unit.sv
// Channel  | Signals                                   | Word
// in       | s_axis_tvalid/tready/tdata               | one wire byte
// out      | m_axis_tvalid/tready/tdata/tuser/tlast   | header, payload byte or error
// cfg      | cfg_valid/cfg_ready/cfg_data             | max_payload_length
// One byte per cycle in while the queue is not full; each result passes the queue slot
// and then the output register before it is presented.
// The parse state in the front end updates once per byte, the only serial loop.
// The output word stalls into a QUEUE_DEPTH queue; s_axis_tready drops only when it fills.
// rst_n clears the parse phase, queue and output valid; the length limit returns to 2^26.
// After a reserved-bit or oversize error, bytes are taken and dropped until reset.
`timescale 1ns / 1ps

`include "websocket_frame_parser_unit_macros.svh"

module websocket_frame_parser_unit
    import wfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] fin_flag, [4:1] opcode, [5] masked, [32:6] payload_length,
    // [40:33] payload_byte, [41] error_code, [47:42] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]  m_axis_tuser,   // [1:0] kind
    output logic               m_axis_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEN_W-1:0]   cfg_data        // [26:0] max_payload_length
);

    logic [LEN_W-1:0] max_len_reg;
    push_t            push;
    logic             in_error;
    cmd_t             head;
    logic             q_empty;
    logic             q_full;
    logic             q_pop;
    logic             in_fire;

    // Take the limit register write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            max_len_reg <= cfg_data;
        end
    end

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    wfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_byte  (s_axis_tdata),
        .max_len  (max_len_reg),
        .push     (push),
        .in_error (in_error)
    );

    wfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    wfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // An error result never closes a frame
    `WFP_ASSERT_IMP(a_err_not_last, m_axis_tvalid && (m_axis_tuser == KIND_ERROR), !m_axis_tlast)
    // The error state holds until reset
    `WFP_ASSERT_NXT(a_err_sticky, in_error, in_error)
    // Nothing is classified once the error state is reached
    `WFP_ASSERT_IMP(a_err_silent, in_error, !push.valid)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for websocket_frame_parser_unit: streams wire bytes in, checks each output word.
// Depends on wfp_pkg and the unit RTL; holds its own frame parser model for the expected words.
`timescale 1ns / 1ps

module tb_top;
    import wfp_pkg::*;

    localparam int DRAIN_CYCLES = 32;

    typedef enum logic [2:0] {
        PARSE_HDR0,
        PARSE_HDR1,
        PARSE_EXTLEN,
        PARSE_KEY,
        PARSE_DATA,
        PARSE_HALTED
    } parse_phase_t;

    typedef enum int {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } len_form_t;

    // One output word as the parser should emit it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              fin;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } parser_word_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;   // [7:0] in_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [0] fin_flag, [4:1] opcode, [5] masked, [32:6] payload_length,
    // [40:33] payload_byte, [41] error_code, [47:42] zero
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]  m_axis_tuser;         // [1:0] kind
    logic               m_axis_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data  = '0;       // [26:0] max_payload_length

    websocket_frame_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Wire bytes waiting for the driver, and words the parser still owes
    logic [BYTE_W-1:0] wire_bytes[$];
    parser_word_t      parsed_words_due[$];
    int                bytes_sent  = 0;
    int                bytes_taken = 0;
    int                mismatches  = 0;

    // Parser model state
    parse_phase_t      ph        = PARSE_HDR0;
    logic [7:0]        hdr0      = '0;
    logic              mask_bit  = 1'b0;
    logic [63:0]       len_acc   = '0;
    logic [2:0]        cnt       = '0;
    logic [31:0]       key       = '0;
    logic [LEN_W-1:0]  offset    = '0;
    logic [LEN_W-1:0]  size_limit = LIMIT_RESET;

    // Idle pattern state of each side
    int  src_gap = 0;
    int  src_run = 0;
    bit  src_calm = 1'b0;
    int  snk_stall = 0;
    int  snk_run = 0;
    bit  snk_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none in a calm stretch
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build the header word and move on to the payload or the next frame
    task automatic emit_header(output parser_word_t w);
        w        = '0;
        w.kind   = KIND_HEADER;
        w.fin    = hdr0[7];
        w.opcode = hdr0[3:0];
        w.masked = mask_bit;
        w.length = len_acc[LEN_W-1:0];
        w.last   = (len_acc == 0);
        offset   = '0;
        ph       = (len_acc == 0) ? PARSE_HDR0 : PARSE_DATA;
    endtask

    // Length is known: check it against the limit, then key bytes or header
    task automatic close_length(output bit hit, output parser_word_t w);
        w   = '0;
        hit = 1'b1;
        if (len_acc > 64'(size_limit))
        begin
            w.kind = KIND_ERROR;
            w.err  = ERR_TOO_LARGE;
            ph     = PARSE_HALTED;
        end
        else if (mask_bit)
        begin
            cnt = 3'd3;
            key = '0;
            ph  = PARSE_KEY;
            hit = 1'b0;
        end
        else
            emit_header(w);
    endtask

    // Advance the model by one wire byte; hit marks a word produced
    task automatic parse_wire_byte(input logic [7:0] b, output bit hit, output parser_word_t w);
        w   = '0;
        hit = 1'b0;
        case (ph)
            PARSE_HDR0:
            begin
                hdr0 = b;
                ph   = PARSE_HDR1;
            end
            PARSE_HDR1:
            begin
                mask_bit = b[7];
                len_acc  = '0;
                if (hdr0[6:4] != 3'd0)
                begin
                    w.kind = KIND_ERROR;
                    w.err  = ERR_RESERVED;
                    ph     = PARSE_HALTED;
                    hit    = 1'b1;
                end
                else if (b[6:0] == LEN_EXT16)
                begin
                    cnt = 3'd1;
                    ph  = PARSE_EXTLEN;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    cnt = 3'd7;
                    ph  = PARSE_EXTLEN;
                end
                else
                begin
                    len_acc = 64'(b[6:0]);
                    close_length(hit, w);
                end
            end
            PARSE_EXTLEN:
            begin
                len_acc = {len_acc[55:0], b};
                if (cnt == 3'd0)
                    close_length(hit, w);
                else
                    cnt = cnt - 3'd1;
            end
            PARSE_KEY:
            begin
                key = {key[23:0], b};
                if (cnt == 3'd0)
                begin
                    emit_header(w);
                    hit = 1'b1;
                end
                else
                    cnt = cnt - 3'd1;
            end
            PARSE_DATA:
            begin
                hit    = 1'b1;
                w.kind = KIND_PAYLOAD;
                w.data = b ^ (mask_bit ? 8'(key >> (8 * (3 - offset[1:0]))) : 8'h00);
                if (64'(offset) + 64'd1 >= len_acc)
                begin
                    w.last = 1'b1;
                    ph     = PARSE_HDR0;
                    offset = '0;
                end
                else
                    offset = offset + LEN_W'(1);
            end
            default:
                ph = PARSE_HALTED;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Drive wire bytes from the queue, with random gaps between bytes
    always @(posedge clk)
    begin : drive_bytes
        logic             next_valid;
        logic [BYTE_W-1:0] next_data;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (wire_bytes.size() > 0)
                begin
                    next_data  = wire_bytes.pop_front();
                    next_valid = 1'b1;
                    if (src_run == 0)
                    begin
                        src_calm = ($urandom_range(0, 3) == 0);
                        src_run  = $urandom_range(20, 120);
                    end
                    src_run--;
                    src_gap = pick_gap(src_calm);
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    // Stall the output side after taken words
    always @(posedge clk)
    begin : drive_ready
        logic next_ready;
        next_ready = m_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (snk_run == 0)
                begin
                    snk_calm = ($urandom_range(0, 3) == 0);
                    snk_run  = $urandom_range(20, 120);
                end
                snk_run--;
                snk_stall = pick_gap(snk_calm);
            end
            if (snk_stall > 0)
            begin
                snk_stall--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
        end
        m_axis_tready <= next_ready;
    end

    // Predict on each taken byte, compare each taken output word
    always @(posedge clk)
    begin : track_words
        bit           hit;
        parser_word_t w;
        parser_word_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_wire_byte(s_axis_tdata, hit, w);
                if (hit)
                    parsed_words_due.push_back(w);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (parsed_words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = parsed_words_due.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                    check_field("fin_flag", 64'(want.fin), 64'(m_axis_tdata[0]));
                    check_field("opcode", 64'(want.opcode), 64'(m_axis_tdata[4:1]));
                    check_field("masked", 64'(want.masked), 64'(m_axis_tdata[5]));
                    check_field("payload_length", 64'(want.length),
                                64'(m_axis_tdata[32:6]));
                    check_field("payload_byte", 64'(want.data), 64'(m_axis_tdata[40:33]));
                    check_field("error_code", 64'(want.err), 64'(m_axis_tdata[41]));
                    check_field("tdata padding", '0, 64'(m_axis_tdata[47:42]));
                    check_field("last", 64'(want.last), 64'(m_axis_tlast));
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        wire_bytes.push_back(b);
        bytes_sent++;
    endtask

    // Queue one frame; without body it stops after the length field
    task automatic push_frame(input bit fin, input logic [3:0] op, input bit msk,
                              input len_form_t form, input logic [63:0] len,
                              input logic [31:0] k, input bit with_body);
        push_byte({fin, 3'b000, op});
        if (form == LEN_SHORT)
            push_byte({msk, len[6:0]});
        else if (form == LEN_16)
        begin
            push_byte({msk, LEN_EXT16});
            push_byte(len[15:8]);
            push_byte(len[7:0]);
        end
        else
        begin
            push_byte({msk, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                push_byte(len[8*i +: 8]);
        end
        if (with_body)
        begin
            if (msk)
                for (int i = 3; i >= 0; i--)
                    push_byte(k[8*i +: 8]);
            for (longint i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Well-formed frames of random shape, none longer than lim
    task automatic random_frames(input int n_bytes, input logic [LEN_W-1:0] lim);
        int          stop;
        int          r;
        int          cap;
        logic [63:0] len;
        len_form_t   form;
        stop = bytes_sent + n_bytes;
        cap  = (lim < 24) ? int'(lim) : 24;
        while (bytes_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (lim == 0 || r < 10)
                len = '0;
            else if (r < 20)
                len = (lim <= 300) ? 64'(lim) : 64'($urandom_range(126, 300));
            else if (r < 95)
                len = 64'($urandom_range(1, cap));
            else
                len = 64'($urandom_range(1, (lim < 300) ? int'(lim) : 300));
            r = $urandom_range(0, 9);
            if (len >= 126)
                form = (r < 5) ? LEN_16 : LEN_64;
            else if (r < 6)
                form = LEN_SHORT;
            else if (r < 8)
                form = LEN_16;
            else
                form = LEN_64;
            push_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), form, len, $urandom, 1'b1);
        end
    endtask

    // Hold until every byte is taken and every word is out, then drain
    task automatic settle();
        while (bytes_taken != bytes_sent || parsed_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        size_limit = value;
    endtask

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0] small_limit;
        logic [63:0]      big_len;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero-length frames plain and masked, single byte, masked wrap
        push_frame(1'b1, 4'h0, 1'b0, LEN_SHORT, 64'd0, 32'h0, 1'b1);
        push_frame(1'b1, 4'hF, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 1'b1);
        push_frame(1'b0, 4'h9, 1'b0, LEN_SHORT, 64'd1, 32'h0, 1'b1);
        push_frame(1'b1, 4'h2, 1'b1, LEN_SHORT, 64'd5, 32'hA5C3_3C5A, 1'b1);
        random_frames(430, size_limit);
        settle();

        // Limit at zero: only empty frames pass
        write_limit('0);
        random_frames(150, size_limit);
        settle();

        // Small limit, with frames right at the limit
        small_limit = LEN_W'($urandom_range(1, 40));
        write_limit(small_limit);
        push_frame(1'b1, 4'h1, 1'b1, LEN_16, 64'(small_limit), $urandom, 1'b1);
        random_frames(400, size_limit);
        settle();

        // Reset limit, written back explicitly
        write_limit(LIMIT_RESET);
        random_frames(520, size_limit);
        settle();

        // Close with one error; every byte after it is dropped
        if ($urandom_range(0, 1))
        begin
            push_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                       4'($urandom_range(0, 15))});
            push_byte(8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 1))
                big_len = 64'(size_limit) + 64'd1;
            else
                big_len = {32'($urandom) | 32'h1, 32'($urandom)};
            push_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), LEN_64, big_len, $urandom, 1'b0);
        end
        for (int i = 0; i < 30; i++)
            push_byte(8'($urandom));
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
